[rtl/ktg_pkg.sv]
// ktg_pkg: shared types, constants and table functions for the keyed tone generator
// used by ktg_ctrl, ktg_datapath and keyed_tone_generator; depends on nothing
package ktg_pkg;

  localparam int PHASE_BITS_DFLT      = 24;
  localparam int SINE_TABLE_BITS_DFLT = 10;
  localparam int RAMP_TABLE_BITS_DFLT = 8;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_ADDR_W = 2;

  localparam logic [15:0] AMP_ONE   = 16'd32768;
  localparam logic [16:0] RAMP_FULL = 17'd65536;

  localparam logic [23:0] TONE_STEP_RST = 24'd608697;
  localparam logic [16:0] RAMP_STEP_RST = 17'd297;
  localparam logic [15:0] VOLUME_RST    = 16'd32768;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TONE_STEP = 2'd0,
    CFG_RAMP_STEP = 2'd1,
    CFG_VOLUME    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] level;
    logic        segment_start;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               in_ramp;
  } out_word_t;

  // controller to datapath, at most one command per cycle
  typedef struct packed {
    logic load_in;
    logic seg_upd;
    logic amp_mul;
    logic amp_upd;
    logic smp_mul;
    logic out_load;
  } ktg_cmd_t;

  typedef struct packed {
    logic out_free;
  } ktg_sts_t;

  // sin(pi/2 * u) in Q30, u in Q16 (0..65536), odd polynomial in horner form
  function automatic longint unsigned quarter_sine(longint unsigned u);
    longint unsigned u2;
    longint unsigned t;
    u2 = (u * u) >> 16;
    t  = 64'd172273;
    t  = 64'd5026995 - ((u2 * t) >> 16);
    t  = 64'd85569306 - ((u2 * t) >> 16);
    t  = 64'd693598668 - ((u2 * t) >> 16);
    t  = 64'd1686629713 - ((u2 * t) >> 16);
    t  = (u * t) >> 16;
    if (t > 64'd1073741824) begin
      t = 64'd1073741824;
    end
    return t;
  endfunction

  // quarter-wave sine magnitude in Q15, entry j of 2**qbits + 1
  function automatic longint unsigned sine_entry(int unsigned j, int unsigned qbits);
    longint unsigned u;
    longint unsigned m;
    u = longint'(j) << (16 - qbits);
    m = (quarter_sine(u) + 64'd16384) >> 15;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return m;
  endfunction

  // raised-cosine fraction (1 - cos(pi*x))/2 in Q16 for table entry i
  function automatic longint unsigned ramp_entry(int unsigned i, int unsigned rbits);
    longint unsigned v;
    longint unsigned f;
    v = longint'(i) << (16 - rbits);
    if (v < 64'd32768) begin
      f = 64'd1073741824 - quarter_sine(64'd65536 - 2 * v);
    end else begin
      f = 64'd1073741824 + quarter_sine(2 * v - 64'd65536);
    end
    return (f + 64'd16384) >> 15;
  endfunction

endpackage

[rtl/ktg_ctrl.sv]
// ktg_ctrl: sequencer for one sample, steps the datapath through its shared multiplier
// depends on ktg_pkg for the command and status structs
module ktg_ctrl import ktg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ktg_sts_t sts,
  output ktg_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SEG  = 6'b000010,
    S_AMUL = 6'b000100,
    S_AMP  = 6'b001000,
    S_SMUL = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load_in = accept;
        if (accept) state_nxt = S_SEG;
      end
      S_SEG: begin
        cmd.seg_upd = 1'b1;
        state_nxt   = S_AMUL;
      end
      S_AMUL: begin
        cmd.amp_mul = 1'b1;
        state_nxt   = S_AMP;
      end
      S_AMP: begin
        cmd.amp_upd = 1'b1;
        state_nxt   = S_SMUL;
      end
      S_SMUL: begin
        cmd.smp_mul = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("more than one datapath command in a cycle");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output loaded while the previous word is still held");
  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && !sts.out_free |=> (state_r == S_OUT) && !accept)
    else $error("sequencer left the output step without loading");

endmodule

[rtl/ktg_datapath.sv]
// ktg_datapath: config registers, envelope and phase state, sine and ramp tables,
// one shared 17x17 multiplier and the output register; depends on ktg_pkg
module ktg_datapath import ktg_pkg::*; #(
  parameter int PHASE_BITS      = PHASE_BITS_DFLT,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DFLT,
  parameter int RAMP_TABLE_BITS = RAMP_TABLE_BITS_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_word_t              in_word,
  input  ktg_cmd_t              cmd,
  output ktg_sts_t              sts,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_word_t             out_word
);

  localparam int QBITS      = SINE_TABLE_BITS - 2;
  localparam int QDEPTH     = 2 ** QBITS;
  localparam int RAMP_DEPTH = 2 ** RAMP_TABLE_BITS;

  // constant tables, filled at elaboration
  logic [14:0] sine_rom [QDEPTH+1];
  logic [16:0] ramp_rom [RAMP_DEPTH];

  for (genvar j = 0; j <= QDEPTH; j++) begin : g_sine
    assign sine_rom[j] = 15'(sine_entry(j, QBITS));
  end
  for (genvar i = 0; i < RAMP_DEPTH; i++) begin : g_ramp
    assign ramp_rom[i] = 17'(ramp_entry(i, RAMP_TABLE_BITS));
  end

  // config
  logic [23:0] tone_step_r;
  logic [16:0] ramp_step_r;
  logic [15:0] volume_r;

  // state
  logic [PHASE_BITS-1:0] tone_phase_r;
  logic [15:0] current_amp_r;
  logic [15:0] start_amp_r;
  logic [15:0] target_amp_r;
  logic [16:0] ramp_pos_r;
  logic        ramping_r;
  logic        act_r;
  logic        done_r;
  logic        out_valid_r;

  // per-item working values
  logic        seg_r;
  logic [33:0] mul_r;
  logic [14:0] mag_r;
  logic        neg_r;
  logic [16:0] frac_r;
  out_word_t   out_word_r;

  // ramp amplitude, rounding applied to the magnitude of the step
  logic        amp_up;
  logic [15:0] amp_diff;
  logic [32:0] amp_sum;
  logic [15:0] amp_d;
  logic [15:0] amp_ramp;

  assign amp_up   = (target_amp_r >= start_amp_r);
  assign amp_diff = amp_up ? (target_amp_r - start_amp_r) : (start_amp_r - target_amp_r);
  assign amp_sum  = {1'b0, mul_r[31:0]} + 33'd32768;
  assign amp_d    = amp_sum[31:16];
  assign amp_ramp = amp_up ? (start_amp_r + amp_d) : (start_amp_r - amp_d);

  // shared multiplier
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] mul_p;
  logic        mul_en;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.load_in) begin
      mul_a = {1'b0, in_word.level};
      mul_b = {1'b0, volume_r};
    end else if (cmd.amp_mul) begin
      mul_a = {1'b0, amp_diff};
      mul_b = frac_r;
    end else if (cmd.smp_mul) begin
      mul_a = {1'b0, current_amp_r};
      mul_b = {2'b00, mag_r};
    end
  end

  assign mul_p  = mul_a * mul_b;
  assign mul_en = cmd.load_in || cmd.amp_mul || cmd.smp_mul;

  // segment target, level times volume rounded and saturated at unity
  logic [32:0] tgt_sum;
  logic [17:0] tgt_q;
  logic [15:0] tgt_sat;
  logic        seg_diff;
  logic        ramp_eff;
  logic [16:0] pos_base;
  logic [16:0] ramp_inc;
  logic [17:0] pos_sum;
  logic        pos_done;
  logic [RAMP_TABLE_BITS-1:0] ramp_idx;

  assign tgt_sum  = {1'b0, mul_r[31:0]} + 33'd16384;
  assign tgt_q    = tgt_sum[32:15];
  assign tgt_sat  = (tgt_q > {2'b00, AMP_ONE}) ? AMP_ONE : tgt_q[15:0];
  assign seg_diff = (tgt_sat != current_amp_r);
  assign ramp_eff = seg_r ? seg_diff : ramping_r;
  assign pos_base = seg_r ? '0 : ramp_pos_r;
  assign ramp_inc = (ramp_step_r == '0) ? 17'd1 : ramp_step_r;
  assign pos_sum  = {1'b0, pos_base} + {1'b0, ramp_inc};
  assign pos_done = (pos_sum >= {1'b0, RAMP_FULL});
  assign ramp_idx = pos_sum[15 -: RAMP_TABLE_BITS];

  // sine lookup by quadrant mirror
  logic [SINE_TABLE_BITS-1:0] sine_idx;
  logic [QBITS:0]             sine_q;

  assign sine_idx = tone_phase_r[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign sine_q   = sine_idx[QBITS] ? ((QBITS+1)'(QDEPTH) - {1'b0, sine_idx[QBITS-1:0]})
                                    : {1'b0, sine_idx[QBITS-1:0]};

  // sample: amp * mag * 32767 / 2^30, rounded
  logic [29:0] smp_p;
  logic [45:0] smp_acc;
  logic [15:0] smp_mag;
  logic [15:0] smp_val;
  logic        tone_on;

  assign smp_p   = mul_r[29:0];
  assign smp_acc = {1'b0, smp_p, 15'd0} - {16'd0, smp_p} + (46'd1 << 29);
  assign smp_mag = smp_acc[45:30];
  assign smp_val = neg_r ? (16'd0 - smp_mag) : smp_mag;
  assign tone_on = act_r || (current_amp_r != '0);

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_step_r   <= TONE_STEP_RST;
      ramp_step_r   <= RAMP_STEP_RST;
      volume_r      <= VOLUME_RST;
      tone_phase_r  <= '0;
      current_amp_r <= '0;
      start_amp_r   <= '0;
      target_amp_r  <= '0;
      ramp_pos_r    <= '0;
      ramping_r     <= 1'b0;
      act_r         <= 1'b0;
      done_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TONE_STEP: tone_step_r <= cfg_wdata[23:0];
          CFG_RAMP_STEP: ramp_step_r <= cfg_wdata[16:0];
          CFG_VOLUME:    volume_r    <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      if (cmd.seg_upd) begin
        act_r <= ramp_eff;
        if (seg_r) begin
          target_amp_r <= tgt_sat;
          ramping_r    <= seg_diff;
          // a starting ramp takes its first step below
          if (seg_diff) begin
            start_amp_r <= current_amp_r;
          end else begin
            ramp_pos_r <= '0;
          end
        end
        if (ramp_eff) begin
          ramp_pos_r <= pos_done ? RAMP_FULL : pos_sum[16:0];
          done_r     <= pos_done;
        end
      end

      if (cmd.amp_upd && act_r) begin
        current_amp_r <= done_r ? target_amp_r : amp_ramp;
        if (done_r) ramping_r <= 1'b0;
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        if (tone_on) tone_phase_r <= tone_phase_r + PHASE_BITS'(tone_step_r);
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) seg_r <= in_word.segment_start;
    if (mul_en) mul_r <= mul_p;
    if (cmd.seg_upd) begin
      mag_r  <= sine_rom[sine_q];
      neg_r  <= sine_idx[SINE_TABLE_BITS-1];
      frac_r <= ramp_rom[ramp_idx];
    end
    if (cmd.out_load) begin
      out_word_r.sample  <= $signed(smp_val);
      out_word_r.in_ramp <= act_r;
    end
  end

  a_amp_range: assert property (@(posedge clk) disable iff (!rst_n)
    current_amp_r <= AMP_ONE && target_amp_r <= AMP_ONE)
    else $error("amplitude above unity");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ramp_pos_r <= RAMP_FULL)
    else $error("ramp position past full");
  a_ramp_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.amp_upd && act_r && done_r |=> (current_amp_r == target_amp_r) && !ramping_r)
    else $error("finished ramp did not land on its target");

endmodule

[rtl/keyed_tone_generator.sv]
// keyed_tone_generator: one sine-tone sample per word with a raised-cosine envelope.
// Each accepted word steps through segment update, ramp multiply, amplitude update,
// sample multiply and output load, which waits while out_stall holds a word. The single
// 17x17 multiplier forms target, ramp step and sample in turn, so words do not overlap.
// Reset: synchronous active-low rst_n clears phase, envelope and handshake state and
// loads the register defaults; the sine and ramp tables are constant logic.
module keyed_tone_generator import ktg_pkg::*; #(
  parameter int PHASE_BITS      = PHASE_BITS_DFLT,
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DFLT,
  parameter int RAMP_TABLE_BITS = RAMP_TABLE_BITS_DFLT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data
);

  ktg_cmd_t cmd;
  ktg_sts_t sts;

  ktg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ktg_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .RAMP_TABLE_BITS (RAMP_TABLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_data)
  );

endmodule

[tb/keyed_tone_generator_test.sv]
// keyed_tone_generator_test: self-checking testbench for keyed_tone_generator
// holds a scoreboard class with its own fixed-point tone and envelope predictor
// depends on ktg_pkg and rtl/keyed_tone_generator.sv
module keyed_tone_generator_test import ktg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_SHOWN   = 10;
  localparam int SEG_PCT     = 6;

  class tone_scoreboard;
    bit [23:0] tone_step = TONE_STEP_RST;
    bit [16:0] ramp_step = RAMP_STEP_RST;
    bit [15:0] volume    = VOLUME_RST;
    bit [23:0] phase;
    bit [15:0] amp;
    bit [15:0] ramp_from;
    bit [15:0] ramp_to;
    bit [16:0] ramp_pos;
    bit        ramping;
    out_word_t expected_samples[$];
    int        errors;

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TONE_STEP: tone_step = data[23:0];
        CFG_RAMP_STEP: ramp_step = data[16:0];
        CFG_VOLUME:    volume    = data[15:0];
        default: ;
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_SHOWN) begin
        $display("%0t: %s", $time, msg);
      end
    endfunction

    // sin(pi/2 * u) in Q30, u in Q16
    function longint unsigned quarter_wave(longint unsigned u);
      longint unsigned coef[4];
      longint unsigned u2;
      longint unsigned acc;
      coef = '{64'd5026995, 64'd85569306, 64'd693598668, 64'd1686629713};
      u2 = (u * u) >> 16;
      acc = 64'd172273;
      foreach (coef[i]) begin
        acc = coef[i] - ((u2 * acc) >> 16);
      end
      acc = (u * acc) >> 16;
      return (acc > 64'd1073741824) ? 64'd1073741824 : acc;
    endfunction

    // sample for the present phase and amplitude, then step the phase
    function bit [15:0] tone_output();
      bit [9:0]        idx;
      longint unsigned u;
      longint unsigned mag;
      longint unsigned s;
      idx = phase[23:14];
      u = {48'd0, idx[7:0], 8'd0};
      if (idx[8]) begin
        u = 64'd65536 - u;
      end
      mag = (quarter_wave(u) + 64'd16384) >> 15;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      s = (amp * mag * 64'd32767 + 64'd536870912) >> 30;
      phase = phase + tone_step;
      return idx[9] ? (16'd0 - s[15:0]) : s[15:0];
    endfunction

    // raised-cosine fraction in Q16, coarse table step of the position
    function longint unsigned envelope_fraction();
      longint unsigned v;
      longint unsigned f;
      v = {48'd0, ramp_pos[15:8], 8'd0};
      if (v < 64'd32768) begin
        f = 64'd1073741824 - quarter_wave(64'd65536 - 2 * v);
      end else begin
        f = 64'd1073741824 + quarter_wave(2 * v - 64'd65536);
      end
      return (f + 64'd16384) >> 15;
    endfunction

    // rounding is on the magnitude of the swing
    function bit [15:0] envelope_amp(longint unsigned frac);
      longint unsigned d;
      if (ramp_to >= ramp_from) begin
        d = ((ramp_to - ramp_from) * frac + 64'd32768) >> 16;
        return ramp_from + d[15:0];
      end
      d = ((ramp_from - ramp_to) * frac + 64'd32768) >> 16;
      return ramp_from - d[15:0];
    endfunction

    function out_word_t predict_sample(in_word_t w);
      out_word_t       r;
      longint unsigned t;
      longint unsigned step;
      longint unsigned p;
      r.sample  = '0;
      r.in_ramp = 1'b0;
      if (w.segment_start) begin
        t = (w.level * volume + 64'd16384) >> 15;
        if (t > 64'd32768) begin
          t = 64'd32768;
        end
        ramp_to  = t[15:0];
        ramp_pos = '0;
        ramping  = (ramp_to != amp);
        if (ramping) begin
          ramp_from = amp;
        end
      end
      if (ramping) begin
        step = (ramp_step == 0) ? 64'd1 : ramp_step;
        p = ramp_pos + step;
        if (p >= 64'd65536) begin
          ramp_pos = RAMP_FULL;
          amp      = ramp_to;
          ramping  = 1'b0;
        end else begin
          ramp_pos = p[16:0];
          amp      = envelope_amp(envelope_fraction());
        end
        r.sample  = tone_output();
        r.in_ramp = 1'b1;
      end else if (amp != 0) begin
        r.sample = tone_output();
      end
      return r;
    endfunction

    function void note_word(in_word_t w);
      expected_samples.push_back(predict_sample(w));
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_samples.size() == 0) begin
        report($sformatf("unexpected word: sample %0d in_ramp %0b", got.sample, got.in_ramp));
        return;
      end
      want = expected_samples.pop_front();
      if (got.sample !== want.sample) begin
        report($sformatf("sample: expected %0d, got %0d", want.sample, got.sample));
      end
      if (got.in_ramp !== want.in_ramp) begin
        report($sformatf("in_ramp: expected %0b, got %0b", want.in_ramp, got.in_ramp));
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_data;

  tone_scoreboard sb = new();
  int  cycles;
  int  words_sent;
  int  tx_idle_pct = 38;
  int  rx_idle_pct = 71;
  int  hold_left;
  bit  hold_request;

  keyed_tone_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_word(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_word(out_data);
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic send_word(in_word_t w);
    if (words_sent < 280) begin
      tx_idle_pct = 38;
      rx_idle_pct = 71;
    end else if (words_sent < 540) begin
      tx_idle_pct = 71;
      rx_idle_pct = 38;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_fields(logic [15:0] level, logic seg);
    in_word_t w;
    w.level         = level;
    w.segment_start = seg;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.expected_samples.size() != 0) begin
      @(negedge clk);
    end
  endtask

  function automatic logic [15:0] random_level();
    logic [15:0] lvl;
    case ($urandom_range(9))
      0: lvl = 16'd0;
      1: lvl = 16'd32768;
      // lands on the present amplitude when the volume is unity
      2: lvl = (sb.volume == 16'd32768) ? sb.amp : 16'($urandom_range(32768));
      3: lvl = 16'($urandom);
      default: lvl = 16'($urandom_range(32768));
    endcase
    return lvl;
  endfunction

  task automatic run_phase(logic [23:0] ts, logic [16:0] rs, logic [15:0] vol, int n);
    wait_drained();
    write_reg(CFG_TONE_STEP, ts);
    write_reg(CFG_RAMP_STEP, {7'd0, rs});
    write_reg(CFG_VOLUME, {8'd0, vol});
    repeat (n) begin
      send_fields(random_level(), $urandom_range(99) < SEG_PCT);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    write_reg(CFG_TONE_STEP, 24'd1398101);
    write_reg(CFG_RAMP_STEP, 24'd5000);
    write_reg(CFG_VOLUME, 24'd32768);
    write_reg(CFG_SPARE, 24'hFFFFFF);

    // silent start, then a segment whose target equals the idle amplitude
    send_fields(16'd0, 1'b0);
    send_fields(16'd0, 1'b1);
    // level above unity saturates
    send_fields(16'hFFFF, 1'b1);
    repeat (3) send_fields(16'($urandom), 1'b0);
    // restart mid-ramp, then run it out past full scale
    send_fields(16'd16384, 1'b1);
    repeat (13) send_fields(16'($urandom), 1'b0);
    send_fields(sb.amp, 1'b1);
    send_fields(16'd32768, 1'b1);
    repeat (2) send_fields(16'd0, 1'b0);
    // equal target while ramping freezes the envelope
    send_fields(sb.amp, 1'b1);
    send_fields(16'd0, 1'b0);
    send_fields(16'd0, 1'b1);

    run_phase(24'd608697, 17'd297, 16'd32768, 160);
    run_phase(24'd8388608, 17'd65536, 16'd0, 50);
    run_phase(24'd0, 17'd0, 16'hFFFF, 60);
    run_phase(24'hFFFFFF, 17'h1FFFF, 16'd20000, 80);
    run_phase(24'($urandom), 17'($urandom_range(9000, 1)), 16'($urandom_range(32768)), 200);
    wait_drained();
    hold_request = 1'b1;
    run_phase(24'($urandom), 17'($urandom_range(3000, 1)), 16'd32768, 200);

    wait_drained();
    repeat (20) @(negedge clk);
    if (sb.expected_samples.size() != 0) begin
      sb.report($sformatf("%0d expected words never arrived", sb.expected_samples.size()));
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
